// ===== hdl/gse_pkg.sv =====
// Shared types, constants and helpers for the grey Sobel edge pipeline.
// No dependencies; every other file imports this package.
package gse_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int WINDOW       = 3;
   localparam int TAP_COUNT    = WINDOW * WINDOW;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS   = 11;
   localparam int HEIGHT_BITS  = 13;
   // the input row runs up to height + 1 while draining
   localparam int ROW_BITS     = HEIGHT_BITS + 1;
   localparam int TAP_IDX_BITS = $clog2(TAP_COUNT);
   localparam int ACC_BITS     = 21;
   localparam int SUMSQ_BITS   = 17;
   localparam int ROOT_BITS    = 9;
   localparam int ROOT_IDX_BITS = 4;
   localparam int CSR_DATA_BITS = 40;
   localparam int CSR_IDX_BITS  = 3;
   localparam int DIV3_MUL      = 683;   // floor(x/3) == (x*683)>>11 for x < 2045
   localparam int DIV3_SHIFT    = 11;

   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GX_LOW       = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GX_HIGH      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GY_LOW       = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GY_HIGH      = 3'd5;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] edge_value;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic                    accept;
      logic                    step;
      logic                    tap;
      logic [TAP_IDX_BITS-1:0] tap_index;
      logic                    square;
      logic                    root;
      logic [ROOT_IDX_BITS-1:0] root_bit;
      logic                    load_out;
   } cmd_type;

   typedef struct packed {
      logic ignore_item;
      logic has_out;
      logic out_free;
   } status_type;

   function automatic logic [1:0] tap_row(input logic [TAP_IDX_BITS-1:0] k);
      if (k < TAP_IDX_BITS'(WINDOW)) return 2'd0;
      if (k < TAP_IDX_BITS'(2 * WINDOW)) return 2'd1;
      return 2'd2;
   endfunction

   function automatic logic [1:0] tap_col(input logic [TAP_IDX_BITS-1:0] k);
      logic [TAP_IDX_BITS-1:0] c;
      c = k;
      if (k >= TAP_IDX_BITS'(2 * WINDOW)) c = k - TAP_IDX_BITS'(2 * WINDOW);
      else if (k >= TAP_IDX_BITS'(WINDOW)) c = k - TAP_IDX_BITS'(WINDOW);
      return c[1:0];
   endfunction

endpackage

// ===== hdl/gse_ctrl.sv =====
// Sequencer for the edge pipeline: walks one transaction through
// step, tap accumulation, squaring, root and output. Uses gse_pkg.
module gse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  gse_pkg::status_type status,
   output gse_pkg::cmd_type    cmd
);
   import gse_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_STEP, ST_TAP, ST_SQUARE, ST_ROOT, ST_OUT
   } state_type;

   state_type                state_ff;
   logic [TAP_IDX_BITS-1:0]  tap_ff;
   logic [ROOT_IDX_BITS-1:0] bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
         bit_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && !status.ignore_item) state_ff <= ST_STEP;
            end
            ST_STEP: begin
               tap_ff   <= '0;
               state_ff <= status.has_out ? ST_TAP : ST_IDLE;
            end
            ST_TAP: begin
               tap_ff <= tap_ff + 1'b1;
               if (tap_ff == TAP_IDX_BITS'(TAP_COUNT - 1)) state_ff <= ST_SQUARE;
            end
            ST_SQUARE: begin
               bit_ff   <= ROOT_IDX_BITS'(ROOT_BITS - 1);
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == '0) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (status.out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.accept    = (state_ff == ST_IDLE) && req_valid && !status.ignore_item;
      cmd.step      = (state_ff == ST_STEP);
      cmd.tap       = (state_ff == ST_TAP);
      cmd.tap_index = tap_ff;
      cmd.square    = (state_ff == ST_SQUARE);
      cmd.root      = (state_ff == ST_ROOT);
      cmd.root_bit  = bit_ff;
      cmd.load_out  = (state_ff == ST_OUT) && status.out_free;
   end

endmodule

// ===== hdl/gse_datapath.sv =====
// Datapath: config registers, grey conversion, line store, window,
// kernel accumulation, root unit and output register. Uses gse_pkg.
module gse_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gse_pkg::req_type                     req_data,
   input  logic                                 csr_write_enable,
   input  logic [gse_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [gse_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  gse_pkg::cmd_type                     cmd,
   output gse_pkg::status_type                  status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output gse_pkg::rsp_type                     rsp_data
);
   import gse_pkg::*;

   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic [39:0] gx_low_ff, gy_low_ff;
   logic [31:0] gx_high_ff, gy_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_BITS'(MAX_WIDTH);
         height_ff  <= HEIGHT_BITS'(1);
         gx_low_ff  <= '0;
         gx_high_ff <= '0;
         gy_low_ff  <= '0;
         gy_high_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff   <= csr_write_data[WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff  <= csr_write_data[HEIGHT_BITS-1:0];
            CSR_GX_LOW:       gx_low_ff  <= csr_write_data;
            CSR_GX_HIGH:      gx_high_ff <= csr_write_data[31:0];
            CSR_GY_LOW:       gy_low_ff  <= csr_write_data;
            CSR_GY_HIGH:      gy_high_ff <= csr_write_data[31:0];
            default: ;
         endcase
      end
   end

   // effective geometry
   logic [WIDTH_BITS-1:0]  eff_w;
   logic [HEIGHT_BITS-1:0] eff_h;
   always_comb begin
      if (width_ff == '0) eff_w = WIDTH_BITS'(1);
      else if (width_ff > WIDTH_BITS'(MAX_WIDTH)) eff_w = WIDTH_BITS'(MAX_WIDTH);
      else eff_w = width_ff;
      eff_h = (height_ff == '0) ? HEIGHT_BITS'(1) : height_ff;
   end

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic draining;
   assign draining = (row_ff >= eff_h);
   assign status.ignore_item = (req_data.op == OP_DRAIN) && !draining;

   // grey = floor((r+g+b)/3) by reciprocal multiply
   logic [9:0]  rgb_sum;
   logic [18:0] div_prod;
   logic [7:0]  grey_ff;
   logic [15:0] mem [MAX_WIDTH];
   logic [15:0] rd_ff;
   assign rgb_sum  = {2'b0, req_data.red} + {2'b0, req_data.green} + {2'b0, req_data.blue};
   assign div_prod = {9'd0, rgb_sum} * 19'(DIV3_MUL);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         grey_ff <= draining ? 8'd0 : div_prod[DIV3_SHIFT +: 8];
         rd_ff   <= mem[col_ff];
      end
   end

   // step: window shift, line store update, output position, counters
   logic                slot;
   logic [7:0]          top_pix, mid_pix;
   logic [15:0]         wr_word;
   logic                ho;
   logic [ROW_BITS-1:0] orow;
   logic [COL_BITS-1:0] ocol;
   logic                last;
   logic [WIDTH_BITS:0] col_inc;
   logic                clear;

   always_comb begin
      slot    = row_ff[0];
      top_pix = slot ? rd_ff[15:8] : rd_ff[7:0];
      mid_pix = slot ? rd_ff[7:0]  : rd_ff[15:8];
      wr_word = slot ? {grey_ff, rd_ff[7:0]} : {rd_ff[15:8], grey_ff};
      if (col_ff != '0) begin
         ho   = (row_ff != '0);
         orow = row_ff - (ho ? ROW_BITS'(1) : ROW_BITS'(0));
         ocol = col_ff - 1'b1;
      end else begin
         ho   = (row_ff >= ROW_BITS'(2));
         orow = row_ff - (ho ? ROW_BITS'(2) : ROW_BITS'(0));
         ocol = COL_BITS'(eff_w - 1'b1);
      end
      ho   = ho && (orow < eff_h) && ({1'b0, ocol} < eff_w);
      last = (orow == eff_h - 1'b1) && ({1'b0, ocol} == eff_w - 1'b1);
      col_inc = {{(WIDTH_BITS - COL_BITS + 1){1'b0}}, col_ff} + 1'b1;
      if (col_inc >= {1'b0, eff_w}) begin
         col_in = '0;
         row_in = row_ff + 1'b1;
      end else begin
         col_in = col_inc[COL_BITS-1:0];
         row_in = row_ff;
      end
      clear = ({1'b0, row_in} > {1'b0, eff_h} + 1'b1) || (ho && last);
   end
   assign status.has_out = ho;

   logic [7:0]          win_ff [TAP_COUNT];
   logic [ROW_BITS-1:0] orow_ff;
   logic [COL_BITS-1:0] ocol_ff;
   logic                last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         for (int i = 0; i < TAP_COUNT; i++) win_ff[i] <= '0;
      end else if (cmd.step) begin
         for (int r = 0; r < WINDOW; r++) begin
            for (int c = 0; c < WINDOW - 1; c++) begin
               win_ff[r*WINDOW + c] <= win_ff[r*WINDOW + c + 1];
            end
         end
         win_ff[WINDOW - 1]       <= top_pix;
         win_ff[2*WINDOW - 1]     <= mid_pix;
         win_ff[3*WINDOW - 1]     <= grey_ff;
         col_ff <= clear ? '0 : col_in;
         row_ff <= clear ? '0 : row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         mem[col_ff] <= wr_word;
         orow_ff     <= orow;
         ocol_ff     <= ocol;
         last_ff     <= last;
      end
   end

   // one kernel tap per cycle, both kernels in parallel
   logic [71:0]            gx_taps, gy_taps;
   logic [7:0]             tx, ty, pix;
   logic [1:0]             tr, tc;
   logic                   tap_ok;
   logic signed [16:0]     px, py;
   logic signed [ACC_BITS-1:0] ax_ff, ay_ff, ax_in, ay_in;

   always_comb begin
      gx_taps = {gx_high_ff, gx_low_ff};
      gy_taps = {gy_high_ff, gy_low_ff};
      tx  = gx_taps[{cmd.tap_index, 3'b000} +: 8];
      ty  = gy_taps[{cmd.tap_index, 3'b000} +: 8];
      pix = win_ff[cmd.tap_index];
      tr  = tap_row(cmd.tap_index);
      tc  = tap_col(cmd.tap_index);
      tap_ok = 1'b1;
      if (tr == 2'd0 && orow_ff == '0) tap_ok = 1'b0;
      if (tr == 2'd2 && ({1'b0, orow_ff} + 1'b1 >= {1'b0, eff_h})) tap_ok = 1'b0;
      if (tc == 2'd0 && ocol_ff == '0) tap_ok = 1'b0;
      if (tc == 2'd2 && ({1'b0, ocol_ff} + 1'b1 >= eff_w)) tap_ok = 1'b0;
      px = $signed(tx) * $signed({1'b0, pix});
      py = $signed(ty) * $signed({1'b0, pix});
      ax_in = ax_ff + (tap_ok ? ACC_BITS'(px) : '0);
      ay_in = ay_ff + (tap_ok ? ACC_BITS'(py) : '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         ax_ff <= '0;
         ay_ff <= '0;
      end else if (cmd.tap) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
   end

   // clamp, square, then bitwise root
   function automatic logic [7:0] clamp8(input logic signed [ACC_BITS-1:0] v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   logic [7:0]            sx, sy;
   logic [SUMSQ_BITS-1:0] sumsq_ff;
   logic [ROOT_BITS-1:0]  res_ff, trial;
   logic [2*ROOT_BITS-1:0] trial_sq;

   always_comb begin
      sx       = clamp8(ax_ff);
      sy       = clamp8(ay_ff);
      trial    = res_ff | (ROOT_BITS'(1) << cmd.root_bit);
      trial_sq = trial * trial;
   end

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sumsq_ff <= SUMSQ_BITS'({8'd0, sx} * {8'd0, sx}) + SUMSQ_BITS'({8'd0, sy} * {8'd0, sy});
         res_ff   <= '0;
      end else if (cmd.root) begin
         if (trial_sq <= (2*ROOT_BITS)'(sumsq_ff)) res_ff <= trial;
      end
   end

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff.edge_value <= res_ff[ROOT_BITS-1] ? 8'd255 : res_ff[7:0];
         rsp_data_ff.frame_end  <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/grey_sobel_edge_pipeline.sv =====
// Top level of the grey Sobel edge pipeline: joins the sequencer and
// the datapath. Depends on gse_pkg, gse_ctrl and gse_datapath.
//
// Usage:
//   req_* carries one pixel transaction (op, red, green, blue); op = drain
//   ticks flush the tail of a frame once all pixels are in. A transaction
//   moves when req_valid is high and req_stall is low.
//   rsp_* carries one result (edge_value, frame_end) under the same rule.
//   csr_* writes the geometry and kernel registers; write only while idle.
// Timing:
//   Transactions are worked one at a time by a sequencer. A drain tick that
//   is dropped is taken without leaving idle; a transaction that yields no
//   result passes accept and window step; one with a result passes accept
//   with line store read, window step, the tap loop over every kernel tap
//   through two multiply-adds (one per kernel), square, the bitwise root
//   over each result bit and output load. A result appears one row plus
//   one pixel behind its input; width+1 drain ticks flush the frame.
// Reset: synchronous; clears counters, window, config registers and output valid.
//   The line store is not cleared.
// Stall: a stalled result holds in the output register; the next transaction
//   is still taken and worked up to its own output load, then waits.
module grey_sobel_edge_pipeline (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gse_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gse_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write_enable,
   input  logic [gse_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [gse_pkg::CSR_DATA_BITS-1:0] csr_write_data
);
   import gse_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: owns the handshake toward the sender
   gse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: storage, arithmetic and the result register
   gse_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

// ===== hdl/gse_checker.sv =====
// Port-level checks for the grey Sobel edge pipeline, bound to the top.
// Depends on gse_pkg and grey_sobel_edge_pipeline.
module gse_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input gse_pkg::rsp_type rsp_data
);
   import gse_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // leaving reset the block is idle and empty
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !req_stall && !rsp_valid)
      else $error("not idle after reset");

   // a new result is only loaded while a transaction is in work
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a transaction in work");

   // a taken pixel with no stall pending starts work unless dropped; stall
   // never rises without a transaction
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("busy without an accepted transaction");

endmodule

bind grey_sobel_edge_pipeline gse_checker u_gse_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== verif/grey_sobel_edge_pipeline_test.sv =====
// Self-checking testbench for the grey Sobel edge pipeline: drives pixel and
// drain transactions, predicts each edge value and checks every result.
// Depends on gse_pkg and the grey_sobel_edge_pipeline top level.
`timescale 1ns / 100ps

module grey_sobel_edge_pipeline_test;
   import gse_pkg::*;

   localparam int CYCLE_LIMIT = 900000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_write_enable;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;

   grey_sobel_edge_pipeline dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Predictor state: geometry, kernels, line store, window and counters.
   logic [WIDTH_BITS-1:0] cfg_width;
   logic [HEIGHT_BITS-1:0] cfg_height;
   logic [39:0] gx_low, gy_low;
   logic [31:0] gx_high, gy_high;
   logic [7:0] line_store [0:2*MAX_WIDTH-1];
   logic [7:0] window_grey [0:TAP_COUNT-1];
   int unsigned in_col, in_row;

   rsp_type expected_edges[$];
   int error_count = 0;
   int cycle_count = 0;
   int result_count = 0;
   int pixel_count = 0;
   int item_count = 0;
   int frame_count = 0;
   bit quiet_tail = 0;
   bit hold_results = 0;

   function automatic int unsigned active_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic int unsigned active_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic int kernel_tap(input logic [39:0] lo, input logic [31:0] hi,
                                     input int k);
      logic signed [7:0] b;
      b = (k < 5) ? lo[8*k +: 8] : hi[8*(k-5) +: 8];
      return b;
   endfunction

   function automatic int unsigned int_sqrt(input int unsigned v);
      int unsigned res, bitv;
      res = 0;
      bitv = 1 << 30;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Advance the predictor by one accepted transaction; return 1 with the
   // expected edge when a result comes out.
   function automatic bit predict_edge(input req_type item, output rsp_type edge_out);
      int unsigned w, h, grey, col, slot, orow, ocol;
      int sx, sy, yr, xc;
      bit draining, has_out, last;
      w = active_width();
      h = active_height();
      draining = in_row >= h;
      grey = 0;
      edge_out = '0;
      if (item.op == OP_DRAIN && !draining) return 0;
      if (!draining) grey = (item.red + item.green + item.blue) / 3;
      col = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
      slot = in_row & 1;
      for (int r = 0; r < WINDOW; r++)
         for (int c = 0; c < WINDOW - 1; c++)
            window_grey[r*WINDOW+c] = window_grey[r*WINDOW+c+1];
      window_grey[2] = line_store[slot*MAX_WIDTH + col];
      window_grey[5] = line_store[(slot^1)*MAX_WIDTH + col];
      window_grey[8] = grey[7:0];
      line_store[slot*MAX_WIDTH + col] = grey[7:0];
      if (in_col >= 1) begin
         has_out = in_row >= 1;
         orow = in_row - (has_out ? 1 : 0);
         ocol = in_col - 1;
      end else begin
         has_out = in_row >= 2;
         orow = in_row - (has_out ? 2 : 0);
         ocol = w - 1;
      end
      has_out = has_out && orow < h && ocol < w;
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!has_out) begin
         if (in_row > h + 1) begin
            in_col = 0;
            in_row = 0;
         end
         return 0;
      end
      sx = 0;
      sy = 0;
      for (int r = 0; r < WINDOW; r++) begin
         yr = int'(orow) - 1 + r;
         if (yr < 0 || yr >= int'(h)) continue;
         for (int c = 0; c < WINDOW; c++) begin
            xc = int'(ocol) - 1 + c;
            if (xc < 0 || xc >= int'(w)) continue;
            sx += kernel_tap(gx_low, gx_high, r*WINDOW+c) * int'(window_grey[r*WINDOW+c]);
            sy += kernel_tap(gy_low, gy_high, r*WINDOW+c) * int'(window_grey[r*WINDOW+c]);
         end
      end
      if (sx < 0) sx = 0;
      if (sx > 255) sx = 255;
      if (sy < 0) sy = 0;
      if (sy > 255) sy = 255;
      grey = int_sqrt(sx*sx + sy*sy);
      last = (orow == h - 1) && (ocol == w - 1);
      edge_out.edge_value = (grey > 255) ? 8'd255 : grey[7:0];
      edge_out.frame_end = last;
      if (last || in_row > h + 1) begin
         in_col = 0;
         in_row = 0;
      end
      return 1;
   endfunction

   // Write one register at a falling edge, mirror it in the predictor.
   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width = value[WIDTH_BITS-1:0];
         CSR_IMAGE_HEIGHT: cfg_height = value[HEIGHT_BITS-1:0];
         CSR_GX_LOW:       gx_low = value[39:0];
         CSR_GX_HIGH:      gx_high = value[31:0];
         CSR_GY_LOW:       gy_low = value[39:0];
         CSR_GY_HIGH:      gy_high = value[31:0];
         default: ;
      endcase
   endtask

   task automatic set_kernels(input logic [39:0] xl, input logic [31:0] xh,
                              input logic [39:0] yl, input logic [31:0] yh);
      write_csr(CSR_GX_LOW, xl);
      write_csr(CSR_GX_HIGH, CSR_DATA_BITS'(xh));
      write_csr(CSR_GY_LOW, yl);
      write_csr(CSR_GY_HIGH, CSR_DATA_BITS'(yh));
   endtask

   // Offer one transaction at the falling edge and hold it until taken.
   // Random gaps precede it when may_idle is set and the quiet tail is off.
   task automatic send_item(input req_type item, input bit may_idle);
      rsp_type edge_exp;
      int gap;
      if (may_idle && !quiet_tail && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 18);
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = item;
      do @(posedge clock); while (req_stall);
      if (predict_edge(item, edge_exp)) expected_edges.push_back(edge_exp);
      if (item.op == OP_PIXEL) pixel_count++;
      item_count++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Wait out every pending result, then let the block settle.
   task automatic wait_idle();
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic req_type random_pixel();
      req_type p;
      p.op = OP_PIXEL;
      p.red = $urandom_range(0, 255);
      p.green = $urandom_range(0, 255);
      p.blue = $urandom_range(0, 255);
      return p;
   endfunction

   // Send one full frame of random pixels followed by its drain ticks.
   task automatic send_frame(input bit may_idle);
      int unsigned w, h;
      req_type item;
      w = active_width();
      h = active_height();
      for (int i = 0; i < w*h; i++) begin
         item = random_pixel();
         // Sprinkle early drain ticks; they must be ignored.
         if ($urandom_range(0, 15) == 0) begin
            item.op = OP_DRAIN;
            send_item(item, may_idle);
            item.op = OP_PIXEL;
         end
         send_item(item, may_idle);
      end
      for (int i = 0; i <= w; i++) begin
         item = random_pixel();
         // Pixels while draining act as drain ticks.
         item.op = ($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN;
         send_item(item, may_idle);
      end
      frame_count++;
   endtask

   // Result side: random stall bursts, one long hold-off on request.
   initial begin
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18) - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (expected_edges.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result edge=%0d frame_end=%0b", $time,
                     rsp_data.edge_value, rsp_data.frame_end);
         end else begin
            want = expected_edges.pop_front();
            if (rsp_data.edge_value !== want.edge_value) begin
               error_count++;
               $display("%0t: edge_value expected %0d actual %0d", $time,
                        want.edge_value, rsp_data.edge_value);
            end
            if (rsp_data.frame_end !== want.frame_end) begin
               error_count++;
               $display("%0t: frame_end expected %0b actual %0b", $time,
                        want.frame_end, rsp_data.frame_end);
            end
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Directed rows: geometry, kernels and one pixel; edge = -1 means the
   // predictor decides, otherwise the expected edge is typed in.
   typedef struct {
      logic [WIDTH_BITS-1:0] width;
      logic [HEIGHT_BITS-1:0] height;
      logic [39:0] gx_lo;
      logic [31:0] gx_hi;
      logic [39:0] gy_lo;
      logic [31:0] gy_hi;
      logic [7:0] red, green, blue;
      int edge_typed;
   } directed_row;

   directed_row directed_rows [8] = '{
      // 1x1 image, centre tap +1: edge = grey of the pixel.
      '{11'd1, 13'd1, 40'h00_0000_0000 | (40'h01 << 32), 32'h0, 40'h0, 32'h0,
        8'd255, 8'd255, 8'd255, 255},
      '{11'd1, 13'd1, 40'h01_0000_0000, 32'h0, 40'h0, 32'h0, 8'd0, 8'd0, 8'd0, 0},
      '{11'd1, 13'd1, 40'h01_0000_0000, 32'h0, 40'h0, 32'h0, 8'd1, 8'd1, 8'd2, 1},
      // Negative centre: sum clamps to zero.
      '{11'd1, 13'd1, 40'h80_0000_0000, 32'h0, 40'h0, 32'h0, 8'd200, 8'd9, 8'd7, 0},
      // Both kernels +127 at centre: saturation at 255.
      '{11'd1, 13'd1, 40'h7F_0000_0000, 32'h0, 40'h7F_0000_0000, 32'h0,
        8'd3, 8'd3, 8'd3, 255},
      // gx 3, gy 4 scaled: grey 10 -> sqrt(30^2+40^2) = 50.
      '{11'd1, 13'd1, 40'h03_0000_0000, 32'h0, 40'h04_0000_0000, 32'h0,
        8'd10, 8'd10, 8'd10, 50},
      // Width 0 and height 0 behave as 1.
      '{11'd0, 13'd0, 40'h01_0000_0000, 32'h0, 40'h0, 32'h0, 8'd90, 8'd0, 8'd0, 30},
      // All taps -1 / +1 on a 1x1 frame: only the centre counts.
      '{11'd1, 13'd1, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 40'h01_0101_0101, 32'h0101_0101,
        8'd60, 8'd60, 8'd60, 60}
   };

   initial begin
      req_type item;
      rsp_type dummy;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_write_data = '0;
      cfg_width = 11'd1024;
      cfg_height = 13'd1;
      gx_low = '0;
      gx_high = '0;
      gy_low = '0;
      gy_high = '0;
      for (int i = 0; i < 2*MAX_WIDTH; i++) line_store[i] = 8'd0;
      for (int i = 0; i < TAP_COUNT; i++) window_grey[i] = 8'd0;
      in_col = 0;
      in_row = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: each row is a 1x1 frame plus its two drain ticks.
      foreach (directed_rows[i]) begin
         write_csr(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(directed_rows[i].width));
         write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(directed_rows[i].height));
         set_kernels(directed_rows[i].gx_lo, directed_rows[i].gx_hi,
                     directed_rows[i].gy_lo, directed_rows[i].gy_hi);
         item = '{OP_DRAIN, 8'd0, 8'd0, 8'd0};
         send_item(item, 1'b0);  // drain before frame end: ignored
         item = '{OP_PIXEL, directed_rows[i].red, directed_rows[i].green,
                  directed_rows[i].blue};
         send_item(item, 1'b0);
         item.op = OP_DRAIN;
         send_item(item, 1'b0);
         item = '{OP_PIXEL, 8'hAA, 8'h55, 8'hFF};  // pixel while draining
         send_item(item, 1'b0);
         if (directed_rows[i].edge_typed >= 0 && expected_edges.size() == 1) begin
            expected_edges[0].edge_value = directed_rows[i].edge_typed[7:0];
            expected_edges[0].frame_end = 1'b1;
         end
         wait_idle();
      end

      // Sobel gy and a non-Sobel gx kernel on small frames, with random idling.
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(5));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(4));
      set_kernels({8'h02, 8'h00, 8'hFE, 8'h01, 8'hFF}, {8'hFF, 8'h01, 8'h00, 8'h01},
                  {8'h00, 8'h00, 8'h01, 8'h02, 8'h01}, {8'hFF, 8'hFE, 8'hFF, 8'h00});
      send_frame(1'b1);

      // Long receiver hold-off while the sender keeps offering: fills the block.
      hold_results = 1'b1;
      fork
         send_frame(1'b0);
         begin
            repeat (400) @(negedge clock);
            hold_results = 1'b0;
         end
      join
      wait_idle();

      // Wider frame: three rows of sixteen pixels.
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(16));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(3));
      send_frame(1'b1);
      wait_idle();

      // Random kernels and small random geometries; sender pauses between.
      while (item_count < 860) begin
         write_csr(CSR_IMAGE_WIDTH, CSR_DATA_BITS'($urandom_range(1, 9)));
         write_csr(CSR_IMAGE_HEIGHT,
                   CSR_DATA_BITS'(($urandom_range(0, 5) == 0) ? 9 : $urandom_range(1, 7)));
         set_kernels(40'({$urandom, $urandom}), 32'($urandom),
                     40'({$urandom, $urandom}), 32'($urandom));
         if (item_count > 700) quiet_tail = 1'b1;
         send_frame(1'b1);
         wait_idle();
      end

      // Top height value: the height register is written with 8191 and the width
      // with 1; no frame is sent at that geometry.
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(13'h1FFF));
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(1));
      wait_idle();

      $display("covered %0d frames, %0d transactions, %0d results checked",
               frame_count, item_count, result_count);
      $display("directed extremes, sobel kernels, long stall, random kernels");
      if (error_count == 0 && expected_edges.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/gse_pkg.sv
hdl/gse_ctrl.sv
hdl/gse_datapath.sv
hdl/grey_sobel_edge_pipeline.sv
hdl/gse_checker.sv
verif/grey_sobel_edge_pipeline_test.sv
